@@ hdl/msg_pkg.sv @@
// package for the signed graph spin update unit: types, constants, codes
package msg_pkg;

  localparam int NODES_DEF      = 1024;
  localparam int MAX_DEGREE_DEF = 8;
  localparam int LEVELS         = 8;

  typedef enum logic [2:0] {
    MODE_ADD_EDGE = 3'd0,
    MODE_SET_THR  = 3'd1,
    MODE_SET_SPIN = 3'd2,
    MODE_UPDATE   = 3'd3,
    MODE_COMMIT   = 3'd4,
    MODE_MEASURE  = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_SELF     = 2'd2,
    ST_RANGE    = 2'd3
  } status_t;

  localparam logic CFG_DEFERRED = 1'b0;
  localparam logic CFG_NODES    = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_DECODE,
    S_EDGE_RD,
    S_EDGE_WR,
    S_UPD_RD,
    S_UPD_NB,
    S_UPD_ACC,
    S_UPD_DEC,
    S_COMMIT,
    S_MEAS_NODE,
    S_MEAS_NB,
    S_MEAS_ACC,
    S_DONE
  } state_t;

  // control from the sequencer to the shared accumulator
  typedef struct packed {
    logic clear;
    logic add;
    logic sub;
  } acc_ctl_t;

endpackage

@@ hdl/msg_accum.sv @@
// shared saturating-free accumulator for neighbor sums and energy
module msg_accum #(
  parameter int W = 16
) (
  input  logic                clk,
  input  msg_pkg::acc_ctl_t   ctl,
  input  logic signed [1:0]   term,
  output logic signed [W-1:0] total
);

  logic signed [W-1:0] acc;

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc <= '0;
    end else if (ctl.add) begin
      acc <= acc + W'(term);
    end else if (ctl.sub) begin
      acc <= acc - W'(term);
    end
  end

  assign total = acc;

endmodule

@@ hdl/metropolis_signed_graph_spin_update_unit.sv @@
// top level: metropolis spin update for an ising model on a signed graph
//
// s_axis carries one command item (add edge, set threshold, set spin,
// update, commit, measure); m_axis returns exactly one result item for it.
// cfg_we/cfg_index/cfg_data write deferred_style (0) and node_count (1).
// one item is handled at a time: s_axis_tready is high only in idle.
// steps per mode, set by single port memory reads in the sequencer:
//   set threshold / set spin / unused mode / out of range or self loop:
//     decode only
//   add edge: two degree reads, then one write of both table entries
//   update: degree and own spin reads, then each neighbor entry and its spin
//   commit: a sweep of the whole store, one spin/pending pair per cycle
//   measure: for each node in use, degree and spin reads, then each neighbor entry
// with the receiver ready, each item passes through done and idle before another
// after reset a clearing pass over every store entry sets spins to +1 and clears
// pending bits and degrees; no item is taken meanwhile.
// the result sits in an output register until m_axis_tready; the block
// stays in its done state while the receiver stalls.
module metropolis_signed_graph_spin_update_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // mode[2:0], node[12:3], other_node[22:13], edge_sign[24:23],
  // spin_value[25], random_fraction[41:26], energy_level[45:42],
  // threshold_value[62:46], zero[63]
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], flipped[2], spin_after[4:3], energy_change[10:5],
  // total_energy[24:11], spin_sum[36:25], zero[39:37]
  output logic [39:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data
);

  localparam int NODES      = msg_pkg::NODES_DEF;
  localparam int MAX_DEGREE = msg_pkg::MAX_DEGREE_DEF;
  localparam int NW = $clog2(NODES);
  localparam int DW = $clog2(MAX_DEGREE + 1);
  localparam int KW = $clog2(MAX_DEGREE);
  localparam int AW = NW + KW;
  localparam int CW = NW + 1;

  // configuration
  logic          deferred_style;
  logic [10:0]   node_count;
  logic [CW:0]   n_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      deferred_style <= 1'b0;
      node_count     <= 11'd1024;
    end else if (cfg_we) begin
      if (cfg_index == msg_pkg::CFG_DEFERRED) deferred_style <= cfg_data[0];
      else node_count <= cfg_data;
    end
  end

  // zero acts as one, above the store acts as the whole store
  always_comb begin
    if (node_count == 11'd0) n_use = (CW+1)'(1);
    else if (32'(node_count) > NODES) n_use = (CW+1)'(NODES);
    else n_use = (CW+1)'(node_count);
  end

  // input fields
  logic [2:0]  in_mode;
  logic [9:0]  in_node, in_other;
  logic [1:0]  in_sign;
  logic        in_spin;
  logic [15:0] in_rnd;
  logic [3:0]  in_level;
  logic [16:0] in_thr;

  // memories
  logic          spin_mem [NODES];
  logic          pend_mem [NODES];
  logic [DW-1:0] deg_mem  [NODES];
  logic [NW-1:0] nb_mem   [NODES*MAX_DEGREE];
  logic [1:0]    sg_mem   [NODES*MAX_DEGREE];
  logic [16:0]   thr_reg  [1:msg_pkg::LEVELS];

  msg_pkg::state_t state, state_next;

  logic [NW-1:0] idx;          // node index / sweep counter
  logic [KW:0]   k;            // neighbor counter
  logic          spin_rd2;
  logic [DW-1:0] deg_a, deg_b;
  logic [NW-1:0] nb_rd;
  logic [1:0]    sg_rd;
  logic          s_self;
  logic [1:0]    status;
  logic [1:0]    dec_status;
  logic          flipped;
  logic signed [1:0] spin_after;
  logic signed [5:0] de_o;
  logic signed [13:0] energy_o;
  logic signed [11:0] ssum_o;
  logic signed [CW+1:0] ssum;
  logic [1:0]    phase;

  msg_pkg::acc_ctl_t  actl;
  logic signed [1:0]  term;
  logic signed [15:0] acc_total;

  msg_accum #(.W(16)) u_acc (.clk(clk), .ctl(actl), .term(term), .total(acc_total));

  logic          a_oor, b_oor;
  assign a_oor = (CW+1)'(in_node) >= n_use || 32'(in_node) >= NODES;
  assign b_oor = (CW+1)'(in_other) >= n_use || 32'(in_other) >= NODES;

  // status known at decode: range test before self loop
  always_comb begin
    dec_status = msg_pkg::ST_OK;
    case (in_mode)
      msg_pkg::MODE_ADD_EDGE: begin
        if (a_oor || b_oor) dec_status = msg_pkg::ST_RANGE;
        else if (in_node == in_other) dec_status = msg_pkg::ST_SELF;
      end
      msg_pkg::MODE_SET_SPIN, msg_pkg::MODE_UPDATE: begin
        if (a_oor) dec_status = msg_pkg::ST_RANGE;
      end
      default: ;
    endcase
  end

  logic [AW-1:0] nb_addr;
  logic          last_node;
  logic [KW:0]   deg_lim;
  assign deg_lim = (KW+1)'(deg_a > DW'(MAX_DEGREE) ? DW'(MAX_DEGREE) : deg_a);
  assign last_node = (CW+1)'(idx) + 1'b1 >= n_use;
  assign nb_addr = {idx, k[KW-1:0]};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      msg_pkg::S_CLEAR: if (32'(idx) == NODES - 1) state_next = msg_pkg::S_IDLE;
      msg_pkg::S_IDLE: if (s_axis_tvalid) state_next = msg_pkg::S_DECODE;
      msg_pkg::S_DECODE: begin
        case (in_mode)
          msg_pkg::MODE_ADD_EDGE:
            state_next = (a_oor || b_oor || in_node == in_other) ?
                         msg_pkg::S_DONE : msg_pkg::S_EDGE_RD;
          msg_pkg::MODE_UPDATE:
            state_next = a_oor ? msg_pkg::S_DONE : msg_pkg::S_UPD_RD;
          msg_pkg::MODE_COMMIT:  state_next = msg_pkg::S_COMMIT;
          msg_pkg::MODE_MEASURE: state_next = msg_pkg::S_MEAS_NODE;
          default:               state_next = msg_pkg::S_DONE;
        endcase
      end
      msg_pkg::S_EDGE_RD: if (phase == 2'd1) state_next = msg_pkg::S_EDGE_WR;
      msg_pkg::S_EDGE_WR: state_next = msg_pkg::S_DONE;
      msg_pkg::S_UPD_RD:
        if (phase == 2'd1) state_next = msg_pkg::S_UPD_NB;
      msg_pkg::S_UPD_NB:
        state_next = (k >= deg_lim) ? msg_pkg::S_UPD_DEC : msg_pkg::S_UPD_ACC;
      msg_pkg::S_UPD_ACC:
        if (phase == 2'd1) state_next = msg_pkg::S_UPD_NB;
      msg_pkg::S_UPD_DEC: state_next = msg_pkg::S_DONE;
      msg_pkg::S_COMMIT: if (32'(idx) == NODES - 1) state_next = msg_pkg::S_DONE;
      msg_pkg::S_MEAS_NODE: if (phase == 2'd1) state_next = msg_pkg::S_MEAS_NB;
      msg_pkg::S_MEAS_NB:
        if (k >= deg_lim) state_next = last_node ? msg_pkg::S_DONE : msg_pkg::S_MEAS_NODE;
        else state_next = msg_pkg::S_MEAS_ACC;
      msg_pkg::S_MEAS_ACC: if (phase == 2'd2) state_next = msg_pkg::S_MEAS_NB;
      msg_pkg::S_DONE: if (m_axis_tready) state_next = msg_pkg::S_IDLE;
      default: state_next = msg_pkg::S_IDLE;
    endcase
  end

  // outputs to the shared accumulator
  always_comb begin
    actl = '0;
    term = '0;
    case (state)
      msg_pkg::S_DECODE: actl.clear = 1'b1;
      msg_pkg::S_UPD_ACC: begin
        if (phase == 2'd1) begin
          // s_j * J
          term = (sg_rd == 2'b00) ? 2'sd0 :
                 ((sg_rd == 2'b01) == spin_rd2) ? 2'sd1 : -2'sd1;
          actl.add = 1'b1;
        end
      end
      msg_pkg::S_MEAS_ACC: begin
        if (phase == 2'd2 && (CW+1)'(nb_rd) > (CW+1)'(idx) && (CW+1)'(nb_rd) < n_use) begin
          // -s_i * s_j * J
          term = (sg_rd == 2'b00) ? 2'sd0 :
                 ((sg_rd == 2'b01) == (s_self == spin_rd2)) ? 2'sd1 : -2'sd1;
          actl.sub = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign s_axis_tready = (state == msg_pkg::S_IDLE);
  assign m_axis_tvalid = (state == msg_pkg::S_DONE);
  assign m_axis_tdata = {3'd0, ssum_o, energy_o, de_o, spin_after, flipped, status};

  // update decision helpers
  logic signed [15:0] de_full;
  logic [15:0] lvl;
  logic [16:0] thr_sel;
  logic        accept;
  assign de_full = s_self ? (acc_total <<< 1) : -(acc_total <<< 1);
  assign lvl     = 16'(de_full >>> 1);
  always_comb begin
    thr_sel = '0;
    for (int l = 1; l <= msg_pkg::LEVELS; l++)
      if (lvl == 16'(l)) thr_sel = thr_reg[l];
  end
  assign accept = (de_full <= 0) || ({1'b0, in_rnd} < thr_sel);

  function automatic logic signed [13:0] sat14(input logic signed [15:0] v);
    if (v > 16'sd8191) return 14'sh1FFF;
    if (v < -16'sd8192) return -14'sd8192;
    return v[13:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= msg_pkg::S_CLEAR;
      idx   <= '0;
      k     <= '0;
      phase <= '0;
      for (int l = 1; l <= msg_pkg::LEVELS; l++) thr_reg[l] <= '0;
    end else begin
      state <= state_next;
      case (state)
        msg_pkg::S_CLEAR: begin
          spin_mem[idx] <= 1'b1;
          pend_mem[idx] <= 1'b0;
          deg_mem[idx]  <= '0;
          idx <= idx + 1'b1;
        end
        msg_pkg::S_IDLE: begin
          if (s_axis_tvalid) begin
            in_mode  <= s_axis_tdata[2:0];
            in_node  <= s_axis_tdata[12:3];
            in_other <= s_axis_tdata[22:13];
            in_sign  <= s_axis_tdata[24:23];
            in_spin  <= s_axis_tdata[25];
            in_rnd   <= s_axis_tdata[41:26];
            in_level <= s_axis_tdata[45:42];
            in_thr   <= s_axis_tdata[62:46];
          end
          phase <= '0;
          k     <= '0;
        end
        msg_pkg::S_DECODE: begin
          status <= dec_status;
          flipped <= 1'b0;
          de_o <= '0;
          energy_o <= '0;
          ssum_o <= '0;
          ssum <= '0;
          phase <= '0;
          k <= '0;
          idx <= (in_mode == msg_pkg::MODE_UPDATE) ? in_node[NW-1:0] : '0;
          spin_after <= (in_mode == msg_pkg::MODE_SET_SPIN && !a_oor) ?
                        (in_spin ? 2'sd1 : -2'sd1) : 2'sd0;
          case (in_mode)
            msg_pkg::MODE_SET_THR: begin
              if (in_level >= 4'd1 && in_level <= 4'(msg_pkg::LEVELS))
                thr_reg[in_level] <= in_thr > 17'h10000 ? 17'h10000 : in_thr;
            end
            msg_pkg::MODE_SET_SPIN: begin
              if (!a_oor) spin_mem[in_node[NW-1:0]] <= in_spin;
            end
            default: ;
          endcase
        end
        msg_pkg::S_EDGE_RD: begin
          if (phase == 2'd0) deg_a <= deg_mem[in_node[NW-1:0]];
          else deg_b <= deg_mem[in_other[NW-1:0]];
          phase <= phase + 1'b1;
        end
        msg_pkg::S_EDGE_WR: begin
          if (deg_a >= DW'(MAX_DEGREE) || deg_b >= DW'(MAX_DEGREE)) begin
            status <= msg_pkg::ST_OVERFLOW;
          end else begin
            nb_mem[{in_node[NW-1:0], deg_a[KW-1:0]}] <= in_other[NW-1:0];
            sg_mem[{in_node[NW-1:0], deg_a[KW-1:0]}] <= in_sign;
            nb_mem[{in_other[NW-1:0], deg_b[KW-1:0]}] <= in_node[NW-1:0];
            sg_mem[{in_other[NW-1:0], deg_b[KW-1:0]}] <= in_sign;
            deg_mem[in_node[NW-1:0]]  <= deg_a + 1'b1;
            deg_mem[in_other[NW-1:0]] <= deg_b + 1'b1;
          end
        end
        msg_pkg::S_UPD_RD: begin
          if (phase == 2'd0) deg_a <= deg_mem[idx];
          else s_self <= spin_mem[idx];
          phase <= phase + 1'b1;
        end
        msg_pkg::S_UPD_NB, msg_pkg::S_MEAS_NB: begin
          nb_rd <= nb_mem[nb_addr];
          sg_rd <= sg_mem[nb_addr];
          phase <= '0;
          if (state == msg_pkg::S_MEAS_NB && k >= deg_lim) begin
            idx <= idx + 1'b1;
            // sums are final here, so the result is ready on entering done
            if (last_node) begin
              energy_o <= sat14(acc_total);
              ssum_o <= 12'(ssum);
            end
          end
        end
        msg_pkg::S_UPD_ACC: begin
          if (phase == 2'd0) begin
            spin_rd2 <= spin_mem[nb_rd];
            phase <= 2'd1;
          end else begin
            k <= k + 1'b1;
            phase <= 2'd0;
          end
        end
        msg_pkg::S_UPD_DEC: begin
          de_o <= (de_full > 16'sd31) ? 6'sd31 : (de_full < -16'sd32) ? -6'sd32 : de_full[5:0];
          flipped <= accept;
          if (deferred_style) begin
            pend_mem[idx] <= accept;
            spin_after <= s_self ? 2'sd1 : -2'sd1;
          end else begin
            if (accept) spin_mem[idx] <= ~s_self;
            spin_after <= (s_self ^ accept) ? 2'sd1 : -2'sd1;
          end
        end
        msg_pkg::S_COMMIT: begin
          spin_mem[idx] <= spin_mem[idx] ^ pend_mem[idx];
          pend_mem[idx] <= 1'b0;
          idx <= idx + 1'b1;
        end
        msg_pkg::S_MEAS_NODE: begin
          if (phase == 2'd0) begin
            deg_a <= deg_mem[idx];
            phase <= 2'd1;
          end else begin
            s_self <= spin_mem[idx];
            ssum <= spin_mem[idx] ? ssum + 1'b1 : ssum - 1'b1;
            k <= '0;
            phase <= '0;
          end
        end
        msg_pkg::S_MEAS_ACC: begin
          if (phase == 2'd0) begin
            spin_rd2 <= spin_mem[nb_rd];
            phase <= 2'd1;
          end else if (phase == 2'd1) begin
            phase <= 2'd2;
          end else begin
            k <= k + 1'b1;
            phase <= 2'd0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ hdl/msg_checker.sv @@
// port checker for the spin update unit, bound to the top level
module msg_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  // no new item while a result is pending
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid)) else $error("ready while result held");

  // result held while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result dropped");

  // accepted item yields no immediate result
  a_lat: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid) else $error("result too early");

  // padding bits stay zero
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[39:37] == 3'd0) else $error("padding set");

endmodule

bind metropolis_signed_graph_spin_update_unit msg_checker u_chk (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);
